// ===== sv/bdl_pkg.sv =====
// Shared definitions for the bounded double-ended list unit.
// Holds operation and status codes, port widths, parameter defaults and
// the control types. Depends on nothing.
package bdl_pkg;

  // Parameter defaults.
  localparam int CAPACITY_DEF   = 256;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed port field widths.
  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 8;
  localparam int ELEMENT_W = 32;
  localparam int SIZE_W    = 9;
  localparam int STATUS_W  = 2;

  // Operation codes. The remaining code is a no-op.
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RM_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RM_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RD_HEAD  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RD_TAIL  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RD_INDEX = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } bdl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic load;    // move the finished result into the output register
  } bdl_cmd_t;

endpackage

// ===== sv/bdl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the element store. Depends on nothing.
module bdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bdl_ctrl.sv =====
// Controller for the bounded double-ended list unit: handshake state machine
// and the output valid flag. Depends on bdl_pkg.
module bdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bdl_pkg::bdl_cmd_t cmd
);

  bdl_pkg::bdl_state_t state;
  bdl_pkg::bdl_state_t state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdl_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bdl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bdl_pkg::S_LOAD;
        end
      end
      bdl_pkg::S_LOAD: begin
        if (!out_valid || out_ready) begin
          state_next = bdl_pkg::S_IDLE;
        end
      end
      default: state_next = bdl_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      bdl_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      bdl_pkg::S_LOAD: begin
        // The result waits here while the previous one is still unclaimed.
        cmd.load = !out_valid || out_ready;
      end
      default: ;
    endcase
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== sv/bdl_dp.sv =====
// Datapath for the bounded double-ended list unit: head pointer, count,
// element store, pending result and output register.
// Depends on bdl_pkg and bdl_ram.
module bdl_dp #(
  parameter int CAPACITY   = bdl_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = bdl_pkg::ELEM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bdl_pkg::bdl_cmd_t               cmd,
  input  logic [bdl_pkg::FUNC_W-1:0]      func,
  input  logic [bdl_pkg::VALUE_W-1:0]     value,
  input  logic [bdl_pkg::POS_W-1:0]       position,
  output logic [bdl_pkg::ELEMENT_W-1:0]   element,
  output logic [bdl_pkg::SIZE_W-1:0]      size,
  output logic [bdl_pkg::STATUS_W-1:0]    status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > bdl_pkg::POS_W) ? CW : bdl_pkg::POS_W;
  localparam logic [AW:0]   CAP_S = (AW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [bdl_pkg::SIZE_W-1:0]   p_size;
  logic [bdl_pkg::STATUS_W-1:0] p_status;
  logic                         p_rd;

  logic [bdl_pkg::STATUS_W-1:0] st;
  logic                         rd_ok;
  logic                         we;
  logic [AW-1:0]                addr;
  logic [ELEM_WIDTH-1:0]        wdata;
  logic [ELEM_WIDTH-1:0]        rdata;

  logic                         full;
  logic                         empty;
  logic [CW-1:0]                cnt_m1;
  logic [XW-1:0]                pos_x;
  logic [XW-1:0]                cnt_x;
  logic [ELEM_WIDTH+bdl_pkg::VALUE_W-1:0]   val_ext;
  logic [ELEM_WIDTH+bdl_pkg::ELEMENT_W-1:0] rd_ext;
  logic [CW+bdl_pkg::SIZE_W-1:0]            size_ext;

  // Physical slot of an offset from a base; both are below the capacity.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[AW-1:0];
  endfunction

  assign full     = (count == CAP_C);
  assign empty    = (count == '0);
  assign cnt_m1   = count - 1'b1;
  assign pos_x    = XW'(position);
  assign cnt_x    = XW'(count);
  assign val_ext  = {{ELEM_WIDTH{1'b0}}, value};
  assign wdata    = val_ext[ELEM_WIDTH-1:0];
  assign rd_ext   = {{bdl_pkg::ELEMENT_W{1'b0}}, rdata};
  assign size_ext = {{bdl_pkg::SIZE_W{1'b0}}, count_next};

  always_comb begin
    head_next  = head;
    count_next = count;
    st         = bdl_pkg::ST_OK;
    rd_ok      = 1'b0;
    we         = 1'b0;
    addr       = head;
    unique case (func)
      bdl_pkg::FN_INS_HEAD: begin
        if (full) begin
          st = bdl_pkg::ST_FULL;
        end else begin
          head_next  = (head == '0) ? LAST : head - 1'b1;
          addr       = head_next;
          we         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      bdl_pkg::FN_INS_TAIL: begin
        if (full) begin
          st = bdl_pkg::ST_FULL;
        end else begin
          addr       = slot(head, count[AW-1:0]);
          we         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      bdl_pkg::FN_RM_HEAD: begin
        if (!empty) begin
          head_next  = (head == LAST) ? '0 : head + 1'b1;
          count_next = cnt_m1;
        end
      end
      bdl_pkg::FN_RM_TAIL: begin
        if (!empty) begin
          count_next = cnt_m1;
        end
      end
      bdl_pkg::FN_RD_HEAD: begin
        if (empty) begin
          st = bdl_pkg::ST_EMPTY;
        end else begin
          rd_ok = 1'b1;
        end
      end
      bdl_pkg::FN_RD_TAIL: begin
        if (empty) begin
          st = bdl_pkg::ST_EMPTY;
        end else begin
          addr  = slot(head, cnt_m1[AW-1:0]);
          rd_ok = 1'b1;
        end
      end
      bdl_pkg::FN_RD_INDEX: begin
        if (pos_x >= cnt_x) begin
          st = bdl_pkg::ST_EMPTY;
        end else begin
          addr  = slot(head, pos_x[AW-1:0]);
          rd_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Pending result, completed by the store's registered read data when it is loaded.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_size   <= size_ext[bdl_pkg::SIZE_W-1:0];
      p_status <= st;
      p_rd     <= rd_ok;
    end
    if (cmd.load) begin
      element <= p_rd ? rd_ext[bdl_pkg::ELEMENT_W-1:0] : '0;
      size    <= p_size;
      status  <= p_status;
    end
  end

  bdl_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept & we),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.accept & rd_ok),
    .raddr (addr),
    .rdata (rdata)
  );

endmodule

// ===== sv/bounded_double_ended_list_unit.sv =====
// Bounded double-ended list unit: a fixed-capacity list kept as a circular
// buffer in a single RAM, with insert and remove at both ends and reads of
// the head, the tail or any position. Every item gives exactly one result.
// An item is handled in order: first it is taken, the head pointer and
// count are updated and the element store is written or read; then the
// registered read data goes into the output register once the previous
// result is taken. The next item is taken as soon as the result is in the
// output register, so no item is taken before the last one is through;
// the single access port of the store and its registered read set this
// limit. The store needs no clearing after reset. Inserts into a full list
// are refused with status 1; removes on an empty list are ignored; reads
// of an empty list or beyond the count return zero with status 2.
// Depends on bdl_pkg, bdl_ctrl, bdl_dp and bdl_ram.
module bounded_double_ended_list_unit #(
  parameter int CAPACITY   = bdl_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = bdl_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdl_pkg::FUNC_W-1:0]    func,
  input  logic [bdl_pkg::VALUE_W-1:0]   value,
  input  logic [bdl_pkg::POS_W-1:0]     position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdl_pkg::ELEMENT_W-1:0] element,
  output logic [bdl_pkg::SIZE_W-1:0]    size,
  output logic [bdl_pkg::STATUS_W-1:0]  status
);

  bdl_pkg::bdl_cmd_t cmd;

  bdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bdl_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .func     (func),
    .value    (value),
    .position (position),
    .element  (element),
    .size     (size),
    .status   (status)
  );

  // One item at a time: the cycle after an accept never takes another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while the previous one is still in progress");

  // A new result only appears from the load cycle, when no item is taken.
  a_result_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result presented without a load cycle");

  // Refused or failed operations never carry an element.
  a_error_no_element: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bdl_pkg::ST_OK) |-> (element == '0))
    else $error("error result carries a nonzero element");

  // The reported size never exceeds the capacity.
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((CAPACITY >= (1 << bdl_pkg::SIZE_W)) || (int'(size) <= CAPACITY)))
    else $error("size beyond capacity");

endmodule
